/* hdl/paged_framebuffer_draw_engine_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the paged framebuffer draw engine.
// Both macros check on the rising clock edge and are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PAGED_FRAMEBUFFER_DRAW_ENGINE_TOP_DEFINES_SVH
`define PAGED_FRAMEBUFFER_DRAW_ENGINE_TOP_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define PFDE_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PFDE_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pfde_pkg.sv */
// ----------------------------------------------------------------------------
// pfde_pkg
// Shared constants, command codes and item types of the draw engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pfde_pkg;

  localparam int SCREEN_WIDTH  = 96;
  localparam int SCREEN_HEIGHT = 65;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(STORE_BYTES);

  localparam logic [2:0] CMD_PIXEL       = 3'd0;
  localparam logic [2:0] CMD_OUTLINE     = 3'd1;
  localparam logic [2:0] CMD_FILL_RECT   = 3'd2;
  localparam logic [2:0] CMD_FILL_SCREEN = 3'd3;
  localparam logic [2:0] CMD_READ        = 3'd4;

  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [7:0] BYTE_ZEROS = 8'h00;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic signed [15:0] rect_width;
    logic signed [15:0] rect_height;
    logic               color;
  } in_item_t;

  typedef struct packed {
    logic [7:0] scan_byte;
    logic       last_of_frame;
  } out_item_t;

  // One byte operation from the sequencer to the read-modify-write unit.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [7:0]        mask;
    logic              color;
    logic              rd;
    logic              last;
  } byte_op_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } rd_result_t;

endpackage

`default_nettype wire

/* hdl/pfde_frame_ram.sv */
// ----------------------------------------------------------------------------
// pfde_frame_ram
// Frame store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfde_frame_ram (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [pfde_pkg::ADDR_W-1:0]  waddr_i,
  input  wire logic [7:0]                   wdata_i,
  input  wire logic                         re_i,
  input  wire logic [pfde_pkg::ADDR_W-1:0]  raddr_i,
  output logic      [7:0]                   rdata_o
);

  logic [7:0] mem_q [pfde_pkg::STORE_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/pfde_walker.sv */
// ----------------------------------------------------------------------------
// pfde_walker
// Command sequencer: turns one command into a stream of byte operations.
// ----------------------------------------------------------------------------
`default_nettype none

module pfde_walker (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cmd_valid_i,
  input  wire pfde_pkg::in_item_t   cmd_i,
  output logic                      idle_o,
  output logic                      op_valid_o,
  output pfde_pkg::byte_op_t        op_o,
  input  wire logic                 op_ready_i
);

  localparam int MAX_DIM = (pfde_pkg::SCREEN_WIDTH > pfde_pkg::SCREEN_HEIGHT) ?
                           pfde_pkg::SCREEN_WIDTH : pfde_pkg::SCREEN_HEIGHT;
  localparam int CRD_W   = $clog2(MAX_DIM + 1);
  localparam int EXT_W   = 18;
  localparam int PAGE_W  = (pfde_pkg::PAGE_COUNT > 1) ? $clog2(pfde_pkg::PAGE_COUNT) : 1;
  localparam int ADDR_W  = pfde_pkg::ADDR_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FILL  = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_PREP  = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;

  // Outline edges, drawn in this order.
  localparam logic [1:0] SUB_TOP    = 2'd0;
  localparam logic [1:0] SUB_BOTTOM = 2'd1;
  localparam logic [1:0] SUB_LEFT   = 2'd2;
  localparam logic [1:0] SUB_RIGHT  = 2'd3;

  localparam logic [ADDR_W-1:0]       LAST_ADDR = ADDR_W'(pfde_pkg::STORE_BYTES - 1);
  localparam logic [ADDR_W-1:0]       ROW_STEP  = ADDR_W'(pfde_pkg::SCREEN_WIDTH);
  localparam logic [CRD_W-1:0]        LIM_X     = CRD_W'(pfde_pkg::SCREEN_WIDTH);
  localparam logic [CRD_W-1:0]        LIM_Y     = CRD_W'(pfde_pkg::SCREEN_HEIGHT);
  localparam logic signed [EXT_W-1:0] ONE_S     = EXT_W'(1);

  function automatic logic [CRD_W-1:0] clamp_crd(input logic signed [EXT_W-1:0] v,
                                                 input logic [CRD_W-1:0] lim);
    logic signed [EXT_W-1:0] lim_s;
    logic [CRD_W-1:0]        res;
    lim_s = $signed(EXT_W'(lim));
    if (v[EXT_W-1]) begin
      res = '0;
    end else if (v > lim_s) begin
      res = lim;
    end else begin
      res = v[CRD_W-1:0];
    end
    return res;
  endfunction

  logic [2:0]              state_q, state_d;
  logic                    color_q, color_d;
  logic                    outline_q, outline_d;
  logic [1:0]              sub_q, sub_d;
  logic [ADDR_W-1:0]       addr_q, addr_d;
  logic [ADDR_W-1:0]       row_q, row_d;
  logic [ADDR_W-1:0]       scan_q, scan_d;
  logic [CRD_W-1:0]        col_q, col_d;
  logic [CRD_W-1:0]        col_lo_q, col_lo_d;
  logic [CRD_W-1:0]        col_end_q, col_end_d;
  logic [PAGE_W-1:0]       page_q, page_d;
  logic [PAGE_W-1:0]       page_end_q, page_end_d;
  logic [2:0]              lo_q, lo_d;
  logic [2:0]              hi_q, hi_d;

  logic signed [EXT_W-1:0] x_q, y_q, xw_q, yh_q;
  logic [CRD_W-1:0]        xa_q, xa_d, xb_q, xb_d, ya_q, ya_d, yb_q, yb_d;

  logic signed [EXT_W-1:0] sx0, sx1, sy0, sy1;
  logic [CRD_W-1:0]        yb_last;
  logic [PAGE_W-1:0]       page_first;
  logic                    sub_done;
  logic [2:0]              hi_cur;
  logic [7:0]              lo_mask, hi_mask;

  // Corners of the current sub-rectangle, end coordinates exclusive.
  always_comb begin
    sx0 = (outline_q && (sub_q == SUB_RIGHT))  ? (xw_q - ONE_S) : x_q;
    sx1 = (outline_q && (sub_q == SUB_LEFT))   ? (x_q + ONE_S)  : xw_q;
    sy0 = (outline_q && (sub_q == SUB_BOTTOM)) ? (yh_q - ONE_S) : y_q;
    sy1 = (outline_q && (sub_q == SUB_TOP))    ? (y_q + ONE_S)  : yh_q;
  end

  assign yb_last    = yb_q - CRD_W'(1);
  assign page_first = PAGE_W'(ya_q >> 3);

  always_comb begin
    state_d    = state_q;
    color_d    = color_q;
    outline_d  = outline_q;
    sub_d      = sub_q;
    addr_d     = addr_q;
    row_d      = row_q;
    scan_d     = scan_q;
    col_d      = col_q;
    col_lo_d   = col_lo_q;
    col_end_d  = col_end_q;
    page_d     = page_q;
    page_end_d = page_end_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    xa_d       = xa_q;
    xb_d       = xb_q;
    ya_d       = ya_q;
    yb_d       = yb_q;
    sub_done   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          color_d   = cmd_i.color;
          outline_d = (cmd_i.cmd == pfde_pkg::CMD_OUTLINE);
          sub_d     = SUB_TOP;
          case (cmd_i.cmd)
            pfde_pkg::CMD_PIXEL,
            pfde_pkg::CMD_OUTLINE,
            pfde_pkg::CMD_FILL_RECT: begin
              state_d = ST_SETUP;
            end
            pfde_pkg::CMD_FILL_SCREEN: begin
              state_d = ST_FILL;
              addr_d  = '0;
            end
            pfde_pkg::CMD_READ: begin
              state_d = ST_READ;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_FILL: begin
        if (op_ready_i) begin
          if (addr_q == LAST_ADDR) begin
            state_d = ST_IDLE;
            addr_d  = '0;
          end else begin
            addr_d = addr_q + ADDR_W'(1);
          end
        end
      end
      ST_SETUP: begin
        xa_d    = clamp_crd(sx0, LIM_X);
        xb_d    = clamp_crd(sx1, LIM_X);
        ya_d    = clamp_crd(sy0, LIM_Y);
        yb_d    = clamp_crd(sy1, LIM_Y);
        state_d = ST_PREP;
      end
      ST_PREP: begin
        if ((xa_q >= xb_q) || (ya_q >= yb_q)) begin
          sub_done = 1'b1;
        end else begin
          col_d      = xa_q;
          col_lo_d   = xa_q;
          col_end_d  = xb_q - CRD_W'(1);
          page_d     = page_first;
          page_end_d = PAGE_W'(yb_last >> 3);
          lo_d       = ya_q[2:0];
          hi_d       = yb_last[2:0];
          row_d      = ADDR_W'(page_first * pfde_pkg::SCREEN_WIDTH) + ADDR_W'(xa_q);
          addr_d     = ADDR_W'(page_first * pfde_pkg::SCREEN_WIDTH) + ADDR_W'(xa_q);
          state_d    = ST_WALK;
        end
      end
      ST_WALK: begin
        if (op_ready_i) begin
          if (col_q == col_end_q) begin
            if (page_q == page_end_q) begin
              sub_done = 1'b1;
            end else begin
              page_d = page_q + PAGE_W'(1);
              lo_d   = 3'd0;
              row_d  = row_q + ROW_STEP;
              addr_d = row_q + ROW_STEP;
              col_d  = col_lo_q;
            end
          end else begin
            col_d  = col_q + CRD_W'(1);
            addr_d = addr_q + ADDR_W'(1);
          end
        end
      end
      ST_READ: begin
        if (op_ready_i) begin
          scan_d  = (scan_q == LAST_ADDR) ? '0 : (scan_q + ADDR_W'(1));
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (sub_done) begin
      if (outline_q && (sub_q != SUB_RIGHT)) begin
        sub_d   = sub_q + 2'd1;
        state_d = ST_SETUP;
      end else begin
        state_d = ST_IDLE;
      end
    end
  end

  // Reset starts a sweep that writes zeros through the whole store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      color_q    <= 1'b0;
      outline_q  <= 1'b0;
      sub_q      <= SUB_TOP;
      addr_q     <= '0;
      row_q      <= '0;
      scan_q     <= '0;
      col_q      <= '0;
      col_lo_q   <= '0;
      col_end_q  <= '0;
      page_q     <= '0;
      page_end_q <= '0;
      lo_q       <= 3'd0;
      hi_q       <= 3'd0;
    end else begin
      state_q    <= state_d;
      color_q    <= color_d;
      outline_q  <= outline_d;
      sub_q      <= sub_d;
      addr_q     <= addr_d;
      row_q      <= row_d;
      scan_q     <= scan_d;
      col_q      <= col_d;
      col_lo_q   <= col_lo_d;
      col_end_q  <= col_end_d;
      page_q     <= page_d;
      page_end_q <= page_end_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && (state_q == ST_IDLE)) begin
      x_q <= EXT_W'(cmd_i.x_pos);
      y_q <= EXT_W'(cmd_i.y_pos);
      if (cmd_i.cmd == pfde_pkg::CMD_PIXEL) begin
        xw_q <= EXT_W'(cmd_i.x_pos) + ONE_S;
        yh_q <= EXT_W'(cmd_i.y_pos) + ONE_S;
      end else begin
        xw_q <= EXT_W'(cmd_i.x_pos) + EXT_W'(cmd_i.rect_width);
        yh_q <= EXT_W'(cmd_i.y_pos) + EXT_W'(cmd_i.rect_height);
      end
    end
    xa_q <= xa_d;
    xb_q <= xb_d;
    ya_q <= ya_d;
    yb_q <= yb_d;
  end

  // Row mask within the current page: the first page starts at the top row,
  // the last page stops at the bottom row.
  assign hi_cur  = (page_q == page_end_q) ? hi_q : 3'd7;
  assign lo_mask = pfde_pkg::BYTE_ONES << lo_q;
  assign hi_mask = pfde_pkg::BYTE_ONES >> (3'd7 - hi_cur);

  assign idle_o     = (state_q == ST_IDLE);
  assign op_valid_o = (state_q == ST_FILL) || (state_q == ST_WALK) || (state_q == ST_READ);

  always_comb begin
    op_o.addr  = (state_q == ST_READ) ? scan_q : addr_q;
    op_o.mask  = (state_q == ST_WALK) ? (lo_mask & hi_mask) : pfde_pkg::BYTE_ONES;
    op_o.color = color_q;
    op_o.rd    = (state_q == ST_READ);
    op_o.last  = (scan_q == LAST_ADDR);
  end

endmodule

`default_nettype wire

/* hdl/pfde_rmw.sv */
// ----------------------------------------------------------------------------
// pfde_rmw
// Read-modify-write unit around the frame store.
// ----------------------------------------------------------------------------
`default_nettype none

module pfde_rmw (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 op_valid_i,
  input  wire pfde_pkg::byte_op_t   op_i,
  output logic                      op_ready_o,
  input  wire logic                 out_free_i,
  output pfde_pkg::rd_result_t      result_o
);

  logic                             phase_q, phase_d;
  pfde_pkg::byte_op_t               pend_q;
  logic                             full;
  logic                             fire;
  logic                             ram_we, ram_re;
  logic [pfde_pkg::ADDR_W-1:0]      ram_waddr;
  logic [7:0]                       ram_wdata, ram_rdata;
  logic [7:0]                       merged;

  // A full-byte write needs no read; any other operation reads, then holds the
  // unit in phase_q, so a following access always sees the written byte.
  assign full       = !op_i.rd && (op_i.mask == pfde_pkg::BYTE_ONES);
  assign op_ready_o = !phase_q && (!op_i.rd || out_free_i);
  assign fire       = op_valid_i && op_ready_o;
  assign phase_d    = fire && !full;

  assign merged = pend_q.color ? (ram_rdata | pend_q.mask) : (ram_rdata & ~pend_q.mask);

  always_comb begin
    ram_re    = fire && !full;
    ram_we    = (fire && full) || (phase_q && !pend_q.rd);
    ram_waddr = phase_q ? pend_q.addr : op_i.addr;
    ram_wdata = phase_q ? merged
                        : (op_i.color ? pfde_pkg::BYTE_ONES : pfde_pkg::BYTE_ZEROS);
  end

  pfde_frame_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (op_i.addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      pend_q <= op_i;
    end
  end

  always_comb begin
    result_o.valid              = phase_q && pend_q.rd;
    result_o.item.scan_byte     = ram_rdata;
    result_o.item.last_of_frame = pend_q.last;
  end

endmodule

`default_nettype wire

/* hdl/paged_framebuffer_draw_engine_top.sv */
// ----------------------------------------------------------------------------
// paged_framebuffer_draw_engine_top: page-ordered monochrome framebuffer.
// Scan read: the input is free again once the read is issued; the byte
// reaches the output register through the store's registered read. Rectangles:
// a setup and a prepare step per edge, then a write per fully and a read and a
// write per partly covered byte; the last write overlaps the next item.
// Reset: a clearing pass writes zeros through the store, input stalled meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_framebuffer_draw_engine_top (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire pfde_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output pfde_pkg::out_item_t       out_data_o
);

  // The frame store has a single port pair, so every byte that is only
  // partly covered costs a read and a write. That memory port is
  // what sets the drawing rate. Commands are taken one at a time: the
  // sequencer stalls the input from the moment it accepts an item until it
  // has issued the last byte operation of that item.

  logic                      in_accept;
  logic                      walker_idle;
  logic                      op_valid;
  logic                      op_ready;
  pfde_pkg::byte_op_t        op;
  pfde_pkg::rd_result_t      rd_result;
  logic                      out_free;
  logic                      out_valid_q, out_valid_d;
  pfde_pkg::out_item_t       out_q;

  assign in_stall_o = !walker_idle;
  assign in_accept  = in_valid_i && !in_stall_o;

  // The sequencer splits each command into byte operations: a pixel is a
  // one by one rectangle, an outline is four thin rectangles, and a screen
  // fill or the clearing pass after reset is a sweep of full-byte writes.
  pfde_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (in_accept),
    .cmd_i       (in_data_i),
    .idle_o      (walker_idle),
    .op_valid_o  (op_valid),
    .op_o        (op),
    .op_ready_i  (op_ready)
  );

  // A scan read is only issued when the output register will have room for
  // its byte, so a stalled consumer never loses a result.
  assign out_free = !out_valid_q || !out_stall_i;

  pfde_rmw u_rmw (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_ready_o (op_ready),
    .out_free_i (out_free),
    .result_o   (rd_result)
  );

  // Output register: holds a finished item while the consumer stalls, which
  // leaves the input side free to take the next command.
  assign out_valid_d = rd_result.valid || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_result.valid) begin
      out_q <= rd_result.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* hdl/pfde_checker.sv */
// ----------------------------------------------------------------------------
// pfde_checker
// Port-level checks of the draw engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "paged_framebuffer_draw_engine_top_defines.svh"

module pfde_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire pfde_pkg::in_item_t   in_data_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire pfde_pkg::out_item_t  out_data_o
);

  // A stalled result stays valid and unchanged.
  `PFDE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "output item changed while stalled")

  // Every defined command keeps the engine busy in the cycle after it is accepted.
  `PFDE_ASSERT_NXT(a_cmd_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && (in_data_i.cmd <= pfde_pkg::CMD_READ), in_stall_o, "engine took a second item right after a command")

  // A new result comes from a scan read issued while busy, via the store's read register.
  `PFDE_ASSERT_IMP(a_out_origin, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o, 2), "result appeared without a scan read in flight")

endmodule

bind paged_framebuffer_draw_engine_top pfde_checker u_pfde_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
